### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared wrappers for concurrent checks, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

### rtl/mrvex_pkg.sv
// ----------------------------------------------------------------------------
// mrvex_pkg
// types and constants shared by the execute stage and its memories
// ----------------------------------------------------------------------------
package mrvex_pkg;

    // default data memory depth in 32-bit words
    localparam int MRVEX_MEM_WORDS = 4096;

    // major opcodes
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_IMM    = 7'h13;
    localparam logic [6:0] OPC_REG    = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    // sub-operation codes
    localparam logic [2:0] F3_BYTE    = 3'd0;
    localparam logic [2:0] F3_WORD    = 3'd2;
    localparam logic [2:0] F3_BYTE_U  = 3'd4;
    localparam logic [2:0] F3_ADD     = 3'd0;
    localparam logic [2:0] F3_JALR    = 3'd0;
    localparam logic [2:0] F3_PRIV    = 3'd0;
    localparam logic [6:0] F7_BASE    = 7'd0;
    localparam logic [11:0] F12_EBREAK = 12'd1;

    // decoded instruction kind
    typedef enum logic [3:0] {
        K_BAD,
        K_LW,
        K_LBU,
        K_SW,
        K_SB,
        K_ADDI,
        K_ADD,
        K_LUI,
        K_JALR,
        K_EBREAK
    } kind_t;

    // input word
    typedef struct packed {
        logic [6:0]         opcode;
        logic [2:0]         funct3;
        logic [6:0]         funct7;
        logic [11:0]        funct12;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic signed [31:0] immediate;
        logic [31:0]        current_pc;
    } in_t;

    // result word
    typedef struct packed {
        logic        status;
        logic        reg_written;
        logic [31:0] write_value;
        logic        jump_taken;
        logic [31:0] jump_target;
        logic        halted;
    } out_t;

    // per-stage instruction state behind the execute stage
    typedef struct packed {
        kind_t       kind;
        logic [4:0]  rd;
        logic        wr;
        logic [31:0] val;
        logic [31:0] sdata;
        logic [1:0]  lane;
        logic [31:0] target;
    } pipe_t;

    // register file write port
    typedef struct packed {
        logic        we;
        logic [4:0]  addr;
        logic [31:0] data;
    } rf_wr_t;

endpackage

### rtl/minirv_execute_stage.sv
// ----------------------------------------------------------------------------
// minirv_execute_stage
// execute stage for an rv32i subset (lw lbu sw sb addi add lui jalr ebreak)
//
// s_ channel takes one decoded instruction word, m_ channel returns one
// result word per instruction, in order. Stages: operand/alu, two stages of
// word index reduction, data memory read, output register. One word is taken
// per cycle except when an instruction needs the result of a load one or two
// places ahead of it; the operand stage then holds until the load word comes
// back from the data memory read port and is bypassed. Results of other
// instructions are bypassed from every later stage without a hold.
// Reset (aresetn low, synchronous) empties all stages and clears the
// register file to zero through per-entry written flags; data memory keeps
// its contents and is undefined until written. While m_ready is low with a
// result waiting, the whole pipe and s_ready hold, and resume on the cycle
// the result is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module minirv_execute_stage
    import mrvex_pkg::*;
#(
    parameter int MEM_WORDS = MRVEX_MEM_WORDS
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int IDX_W = $clog2(MEM_WORDS);

    logic             en_back;
    logic             front_adv;
    logic             hazard;

    logic             a_valid_reg;
    in_t              a_data_reg;
    logic             m1_valid_reg;
    pipe_t            m1_reg;
    logic             m2_valid_reg;
    pipe_t            m2_reg;
    logic             d_valid_reg;
    pipe_t            d_reg;
    logic [IDX_W-1:0] d_idx_reg;
    logic             o_valid_reg;
    out_t             o_data_reg;

    kind_t            a_kind;
    logic             uses1;
    logic             uses2;
    logic [31:0]      rf_rdata1;
    logic [31:0]      rf_rdata2;
    logic [4:0]       rf_ra1;
    logic [4:0]       rf_ra2;
    logic [31:0]      op1;
    logic [31:0]      op2;
    logic [31:0]      sum;
    pipe_t            a_next;
    logic [IDX_W-1:0] m2_idx;
    logic [31:0]      old_word;
    logic [31:0]      d_value;
    logic [31:0]      new_word;
    logic             dm_we;
    rf_wr_t           rf_wr;
    out_t             o_next;

    // pipe moves whenever the output register can take a word
    assign en_back   = !o_valid_reg || m_ready;
    assign front_adv = en_back && !hazard;
    assign s_ready   = front_adv;

    // decode
    always_comb begin
        a_kind = K_BAD;
        unique case (a_data_reg.opcode)
            OPC_LOAD: begin
                if (a_data_reg.funct3 == F3_WORD) begin
                    a_kind = K_LW;
                end else if (a_data_reg.funct3 == F3_BYTE_U) begin
                    a_kind = K_LBU;
                end
            end
            OPC_STORE: begin
                if (a_data_reg.funct3 == F3_WORD) begin
                    a_kind = K_SW;
                end else if (a_data_reg.funct3 == F3_BYTE) begin
                    a_kind = K_SB;
                end
            end
            OPC_IMM: begin
                if (a_data_reg.funct3 == F3_ADD) begin
                    a_kind = K_ADDI;
                end
            end
            OPC_REG: begin
                if (a_data_reg.funct3 == F3_ADD && a_data_reg.funct7 == F7_BASE) begin
                    a_kind = K_ADD;
                end
            end
            OPC_LUI: begin
                a_kind = K_LUI;
            end
            OPC_JALR: begin
                if (a_data_reg.funct3 == F3_JALR) begin
                    a_kind = K_JALR;
                end
            end
            OPC_SYSTEM: begin
                if (a_data_reg.funct3 == F3_PRIV && a_data_reg.funct12 == F12_EBREAK) begin
                    a_kind = K_EBREAK;
                end
            end
            default: begin
                a_kind = K_BAD;
            end
        endcase
    end

    // source usage
    assign uses1 = (a_kind == K_LW) || (a_kind == K_LBU) || (a_kind == K_SW)
                   || (a_kind == K_SB) || (a_kind == K_ADDI) || (a_kind == K_ADD)
                   || (a_kind == K_JALR);
    assign uses2 = (a_kind == K_SW) || (a_kind == K_SB) || (a_kind == K_ADD);

    // hold on a load whose word is not back yet
    always_comb begin
        hazard = 1'b0;
        if (a_valid_reg) begin
            if (m1_valid_reg && m1_reg.wr
                && (m1_reg.kind == K_LW || m1_reg.kind == K_LBU)
                && ((uses1 && m1_reg.rd == a_data_reg.src1_reg)
                    || (uses2 && m1_reg.rd == a_data_reg.src2_reg))) begin
                hazard = 1'b1;
            end
            if (m2_valid_reg && m2_reg.wr
                && (m2_reg.kind == K_LW || m2_reg.kind == K_LBU)
                && ((uses1 && m2_reg.rd == a_data_reg.src1_reg)
                    || (uses2 && m2_reg.rd == a_data_reg.src2_reg))) begin
                hazard = 1'b1;
            end
        end
    end

    // register file, re-read for a held instruction
    assign rf_ra1 = front_adv ? s_data.src1_reg : a_data_reg.src1_reg;
    assign rf_ra2 = front_adv ? s_data.src2_reg : a_data_reg.src2_reg;

    mrvex_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en_back),
        .raddr1  (rf_ra1),
        .raddr2  (rf_ra2),
        .wr      (rf_wr),
        .rdata1  (rf_rdata1),
        .rdata2  (rf_rdata2)
    );

    // operand bypass, youngest producer first
    always_comb begin
        priority if (m1_valid_reg && m1_reg.wr && m1_reg.rd == a_data_reg.src1_reg) begin
            op1 = m1_reg.val;
        end else if (m2_valid_reg && m2_reg.wr && m2_reg.rd == a_data_reg.src1_reg) begin
            op1 = m2_reg.val;
        end else if (d_valid_reg && d_reg.wr && d_reg.rd == a_data_reg.src1_reg) begin
            op1 = d_value;
        end else begin
            op1 = rf_rdata1;
        end
        priority if (m1_valid_reg && m1_reg.wr && m1_reg.rd == a_data_reg.src2_reg) begin
            op2 = m1_reg.val;
        end else if (m2_valid_reg && m2_reg.wr && m2_reg.rd == a_data_reg.src2_reg) begin
            op2 = m2_reg.val;
        end else if (d_valid_reg && d_reg.wr && d_reg.rd == a_data_reg.src2_reg) begin
            op2 = d_value;
        end else begin
            op2 = rf_rdata2;
        end
    end

    // alu and result fields
    assign sum = op1 + a_data_reg.immediate;

    always_comb begin
        a_next        = '0;
        a_next.kind   = a_kind;
        a_next.rd     = a_data_reg.dest_reg;
        a_next.sdata  = op2;
        a_next.lane   = sum[1:0];
        unique case (a_kind)
            K_ADDI:  a_next.val = sum;
            K_ADD:   a_next.val = op1 + op2;
            K_LUI:   a_next.val = a_data_reg.immediate;
            K_JALR:  a_next.val = a_data_reg.current_pc + 32'd4;
            default: a_next.val = '0;
        endcase
        a_next.wr = (a_kind == K_LW || a_kind == K_LBU || a_kind == K_ADDI
                     || a_kind == K_ADD || a_kind == K_LUI || a_kind == K_JALR)
                    && a_data_reg.dest_reg != '0;
        if (a_kind == K_JALR) begin
            a_next.target = {sum[31:1], 1'b0};
        end
    end

    // word index of the effective address
    mrvex_idx_reduce #(
        .MEM_WORDS (MEM_WORDS),
        .IDX_W     (IDX_W)
    ) u_idx_reduce (
        .aclk      (aclk),
        .en        (en_back),
        .word_addr (sum[31:2]),
        .idx       (m2_idx)
    );

    // data memory, read from the index stage, written from the data stage
    assign dm_we = en_back && d_valid_reg && (d_reg.kind == K_SW || d_reg.kind == K_SB);

    mrvex_dmem #(
        .MEM_WORDS (MEM_WORDS),
        .IDX_W     (IDX_W)
    ) u_dmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en_back),
        .ridx    (m2_idx),
        .we      (dm_we),
        .widx    (d_idx_reg),
        .wdata   (new_word),
        .rdata   (old_word)
    );

    // load value and store merge
    always_comb begin
        new_word = old_word;
        if (d_reg.kind == K_SW) begin
            new_word = d_reg.sdata;
        end else begin
            new_word[{d_reg.lane, 3'b000} +: 8] = d_reg.sdata[7:0];
        end
        priority if (d_reg.kind == K_LW) begin
            d_value = old_word;
        end else if (d_reg.kind == K_LBU) begin
            d_value = {24'd0, old_word[{d_reg.lane, 3'b000} +: 8]};
        end else begin
            d_value = d_reg.val;
        end
    end

    // register write back
    always_comb begin
        rf_wr.we   = en_back && d_valid_reg && d_reg.wr;
        rf_wr.addr = d_reg.rd;
        rf_wr.data = d_value;
    end

    // result word
    always_comb begin
        o_next.status      = (d_reg.kind == K_BAD);
        o_next.reg_written = d_reg.wr;
        o_next.write_value = d_reg.wr ? d_value : '0;
        o_next.jump_taken  = (d_reg.kind == K_JALR);
        o_next.jump_target = d_reg.target;
        o_next.halted      = (d_reg.kind == K_EBREAK);
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            d_valid_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
        end else if (en_back) begin
            if (front_adv) begin
                a_valid_reg <= s_valid;
            end
            m1_valid_reg <= a_valid_reg && !hazard;
            m2_valid_reg <= m1_valid_reg;
            d_valid_reg  <= m2_valid_reg;
            o_valid_reg  <= d_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (en_back) begin
            if (front_adv) begin
                a_data_reg <= s_data;
            end
            m1_reg     <= a_next;
            m2_reg     <= m1_reg;
            d_reg      <= m2_reg;
            d_idx_reg  <= m2_idx;
            o_data_reg <= o_next;
        end
    end

    assign m_valid = o_valid_reg;
    assign m_data  = o_data_reg;

    // checks
    `ASSERT_PROP(a_hold_bubble, aclk, aresetn, (a_valid_reg && hazard && en_back) |=> !m1_valid_reg)
    `ASSERT_NEVER(a_rf_x0_write, aclk, aresetn, rf_wr.we && rf_wr.addr == 5'd0)
    `ASSERT_PROP(a_d_to_out, aclk, aresetn, (en_back && d_valid_reg) |=> m_valid)

endmodule

### rtl/mrvex_regfile.sv
// ----------------------------------------------------------------------------
// mrvex_regfile
// 32 x 32 register file, two registered read ports and one write port;
// entries read as zero until written, x0 is never written
// ----------------------------------------------------------------------------
module mrvex_regfile
    import mrvex_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic [4:0]  raddr1,
    input  logic [4:0]  raddr2,
    input  rf_wr_t      wr,
    output logic [31:0] rdata1,
    output logic [31:0] rdata2
);

    logic [31:0] mem [32];
    logic [31:0] written_reg;
    logic [31:0] rd1_reg;
    logic [31:0] rd2_reg;
    logic [4:0]  ra1_reg;
    logic [4:0]  ra2_reg;
    logic        v1_reg;
    logic        v2_reg;
    logic        lw_valid_reg;
    logic [4:0]  lw_addr_reg;
    logic [31:0] lw_data_reg;

    // storage write
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered reads
    always_ff @(posedge aclk) begin
        if (en) begin
            rd1_reg <= mem[raddr1];
            rd2_reg <= mem[raddr2];
            ra1_reg <= raddr1;
            ra2_reg <= raddr2;
            v1_reg  <= written_reg[raddr1];
            v2_reg  <= written_reg[raddr2];
            lw_addr_reg <= wr.addr;
            lw_data_reg <= wr.data;
        end
    end

    // written flags and same-edge write tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg  <= '0;
            lw_valid_reg <= 1'b0;
        end else begin
            if (wr.we) begin
                written_reg[wr.addr] <= 1'b1;
            end
            if (en) begin
                lw_valid_reg <= wr.we;
            end
        end
    end

    // a write at the read edge wins over the stale array word
    always_comb begin
        priority if (lw_valid_reg && lw_addr_reg == ra1_reg) begin
            rdata1 = lw_data_reg;
        end else if (v1_reg) begin
            rdata1 = rd1_reg;
        end else begin
            rdata1 = '0;
        end
        priority if (lw_valid_reg && lw_addr_reg == ra2_reg) begin
            rdata2 = lw_data_reg;
        end else if (v2_reg) begin
            rdata2 = rd2_reg;
        end else begin
            rdata2 = '0;
        end
    end

endmodule

### rtl/mrvex_dmem.sv
// ----------------------------------------------------------------------------
// mrvex_dmem
// data memory of MEM_WORDS words, one registered read and one write port,
// with bypass of a write landing on the word read at the same edge
// ----------------------------------------------------------------------------
module mrvex_dmem
    import mrvex_pkg::*;
#(
    parameter int MEM_WORDS = MRVEX_MEM_WORDS,
    parameter int IDX_W     = $clog2(MEM_WORDS)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [IDX_W-1:0] ridx,
    input  logic             we,
    input  logic [IDX_W-1:0] widx,
    input  logic [31:0]      wdata,
    output logic [31:0]      rdata
);

    logic [31:0]      mem [MEM_WORDS];
    logic [31:0]      rdata_reg;
    logic [IDX_W-1:0] ridx_reg;
    logic             fw_valid_reg;
    logic [IDX_W-1:0] fw_idx_reg;
    logic [31:0]      fw_data_reg;

    // storage write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[widx] <= wdata;
        end
    end

    // registered read and record of the write at the same edge
    always_ff @(posedge aclk) begin
        if (en) begin
            rdata_reg   <= mem[ridx];
            ridx_reg    <= ridx;
            fw_idx_reg  <= widx;
            fw_data_reg <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_valid_reg <= 1'b0;
        end else if (en) begin
            fw_valid_reg <= we;
        end
    end

    // bypass
    assign rdata = (fw_valid_reg && fw_idx_reg == ridx_reg) ? fw_data_reg : rdata_reg;

endmodule

### rtl/mrvex_idx_reduce.sv
// ----------------------------------------------------------------------------
// mrvex_idx_reduce
// two-stage reduction of a word address modulo MEM_WORDS: reciprocal
// multiply for a quotient estimate, then back-multiply, subtract, correct
// ----------------------------------------------------------------------------
module mrvex_idx_reduce
    import mrvex_pkg::*;
#(
    parameter int MEM_WORDS = MRVEX_MEM_WORDS,
    parameter int IDX_W     = $clog2(MEM_WORDS)
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [29:0]      word_addr,
    output logic [IDX_W-1:0] idx
);

    localparam int WA    = 30;
    localparam int RECIP = (2 ** WA) / MEM_WORDS;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int NW    = $clog2(MEM_WORDS + 1);

    logic [WA-1:0]    x1_reg;
    logic [WA-1:0]    x2_reg;
    logic [RW-1:0]    q2_reg;
    logic [WA+RW-1:0] prod;
    logic [RW+NW-1:0] qn;
    logic [WA-1:0]    rem;
    logic [IDX_W:0]   rem_c;

    // quotient estimate, low by at most one
    assign prod = (WA+RW)'(x1_reg) * (WA+RW)'(RW'(RECIP));

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg <= word_addr;
            x2_reg <= x1_reg;
            q2_reg <= prod[WA+RW-1:WA];
        end
    end

    // remainder below twice the depth, one conditional subtract
    assign qn    = (RW+NW)'(q2_reg) * (RW+NW)'(NW'(MEM_WORDS));
    assign rem   = x2_reg - WA'(qn);
    assign rem_c = rem[IDX_W:0];
    assign idx   = (rem_c >= (IDX_W+1)'(MEM_WORDS))
                   ? IDX_W'(rem_c - (IDX_W+1)'(MEM_WORDS))
                   : IDX_W'(rem_c);

endmodule

### dv/tb_minirv_execute_stage.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_minirv_execute_stage
// self-checking bench for the rv32i subset execute stage
//
// Drives decoded instruction words on the s_ channel and checks every result
// word on the m_ channel, in order, against a fixed row result or an in-bench
// instruction-level model with its own register file and data memory. A short
// directed table runs first, then random programmes built around a small
// set of registers and memory words so that load-use and store-load hazards
// come up often. Both sides idle in random bursts; the receiver also holds off
// for one long stretch and the sender once drains the pipe completely.
// ----------------------------------------------------------------------------
module tb_minirv_execute_stage;
    import mrvex_pkg::*;

    localparam int          MEM_DEPTH    = MRVEX_MEM_WORDS;
    localparam logic [31:0] ADDR_SPAN    = MEM_DEPTH * 4;
    localparam int          RANDOM_ITEMS = 800;
    localparam int          TAIL_ITEMS   = 100;
    localparam int          PIPE_LATENCY = 5;
    localparam int          HOLD_AT      = 150;
    localparam int          LONG_HOLD    = 300;
    localparam int          DRAIN_LIMIT  = 10000;

    localparam bit CHECK_FIXED = 1'b1;
    localparam bit CHECK_MODEL = 1'b0;
    localparam logic ST_OK     = 1'b0;
    localparam logic ST_BAD    = 1'b1;

    // encodings outside the implemented subset
    localparam logic [2:0]  F3_HALF    = 3'd1;
    localparam logic [6:0]  F7_ALT     = 7'h20;
    localparam logic [11:0] F12_ECALL  = 12'd0;
    localparam logic [6:0]  OPC_UNUSED = 7'h7f;
    localparam logic [6:0]  OPC_ZERO   = 7'h00;

    typedef struct {
        in_t  word;
        bit   fixed;
        out_t fixed_res;
    } stim_row_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    // model state
    logic [31:0] arch_regs [32];
    logic [31:0] data_words [MEM_DEPTH];
    logic [3:0]  byte_written [MEM_DEPTH];
    int unsigned touched_words [$];

    out_t      expected_results [$];
    stim_row_t directed_rows [$];
    int        mismatch_count    = 0;
    int        results_checked   = 0;
    bit        tail_phase        = 1'b0;
    bit        long_hold_active  = 1'b0;

    minirv_execute_stage #(
        .MEM_WORDS(MEM_DEPTH)
    ) u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // clock and reset
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        aresetn = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // watchdog
    initial begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [31:0] reg_value(logic [4:0] idx);
        return (idx == 5'd0) ? 32'd0 : arch_regs[idx];
    endfunction

    function automatic void mark_written(int unsigned widx, logic [3:0] lanes);
        if (byte_written[widx] == 4'd0)
            touched_words.push_back(widx);
        byte_written[widx] = byte_written[widx] | lanes;
    endfunction

    // instruction-level model: executes one word and returns its result
    function automatic out_t exec_predict(in_t w);
        logic [31:0] rs1v;
        logic [31:0] rs2v;
        logic [31:0] addr;
        logic [31:0] value;
        logic [31:0] target;
        logic        status;
        logic        does_write;
        logic        jump;
        logic        halt;
        int unsigned widx;
        int unsigned lane;
        out_t        r;
        rs1v       = reg_value(w.src1_reg);
        rs2v       = reg_value(w.src2_reg);
        addr       = rs1v + w.immediate;
        widx       = (addr >> 2) % MEM_DEPTH;
        lane       = addr[1:0];
        status     = ST_OK;
        does_write = 1'b0;
        value      = 32'd0;
        jump       = 1'b0;
        target     = 32'd0;
        halt       = 1'b0;
        case (w.opcode)
            OPC_LOAD: begin
                if (w.funct3 == F3_WORD) begin
                    value      = data_words[widx];
                    does_write = 1'b1;
                end else if (w.funct3 == F3_BYTE_U) begin
                    value      = {24'd0, data_words[widx][lane*8 +: 8]};
                    does_write = 1'b1;
                end else begin
                    status = ST_BAD;
                end
            end
            OPC_STORE: begin
                if (w.funct3 == F3_WORD) begin
                    data_words[widx] = rs2v;
                    mark_written(widx, 4'hf);
                end else if (w.funct3 == F3_BYTE) begin
                    data_words[widx][lane*8 +: 8] = rs2v[7:0];
                    mark_written(widx, 4'b0001 << lane);
                end else begin
                    status = ST_BAD;
                end
            end
            OPC_IMM: begin
                if (w.funct3 == F3_ADD) begin
                    value      = addr;
                    does_write = 1'b1;
                end else begin
                    status = ST_BAD;
                end
            end
            OPC_REG: begin
                if (w.funct3 == F3_ADD && w.funct7 == F7_BASE) begin
                    value      = rs1v + rs2v;
                    does_write = 1'b1;
                end else begin
                    status = ST_BAD;
                end
            end
            OPC_LUI: begin
                value      = w.immediate;
                does_write = 1'b1;
            end
            OPC_JALR: begin
                if (w.funct3 == F3_JALR) begin
                    jump       = 1'b1;
                    target     = addr & ~32'd1;
                    value      = w.current_pc + 32'd4;
                    does_write = 1'b1;
                end else begin
                    status = ST_BAD;
                end
            end
            OPC_SYSTEM: begin
                if (w.funct3 == F3_PRIV && w.funct12 == F12_EBREAK)
                    halt = 1'b1;
                else
                    status = ST_BAD;
            end
            default: status = ST_BAD;
        endcase
        // x0 swallows the write
        if (does_write && w.dest_reg != 5'd0) begin
            arch_regs[w.dest_reg] = value;
        end else begin
            does_write = 1'b0;
            value      = 32'd0;
        end
        r.status      = status;
        r.reg_written = does_write;
        r.write_value = value;
        r.jump_taken  = jump;
        r.jump_target = target;
        r.halted      = halt;
        return r;
    endfunction

    function automatic in_t mk_word(logic [6:0] opc, logic [2:0] f3, logic [6:0] f7,
                                    logic [11:0] f12, logic [4:0] rd, logic [4:0] rs1,
                                    logic [4:0] rs2, logic [31:0] imm, logic [31:0] pc);
        in_t w;
        w.opcode     = opc;
        w.funct3     = f3;
        w.funct7     = f7;
        w.funct12    = f12;
        w.dest_reg   = rd;
        w.src1_reg   = rs1;
        w.src2_reg   = rs2;
        w.immediate  = imm;
        w.current_pc = pc;
        return w;
    endfunction

    function automatic out_t mk_res(logic st, logic wr, logic [31:0] val, logic jmp,
                                    logic [31:0] tgt, logic hlt);
        out_t r;
        r.status      = st;
        r.reg_written = wr;
        r.write_value = val;
        r.jump_taken  = jmp;
        r.jump_target = tgt;
        r.halted      = hlt;
        return r;
    endfunction

    task automatic add_row(in_t w, bit fx, out_t r);
        stim_row_t row;
        row.word      = w;
        row.fixed     = fx;
        row.fixed_res = r;
        directed_rows.push_back(row);
    endtask

    // mostly a small register set so that results feed each other
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 7)) : 5'($urandom);
    endfunction

    function automatic in_t make_random_word();
        in_t         w;
        kind_t       kind;
        kind_t       bad_base;
        int unsigned pick;
        int unsigned widx;
        int unsigned lane;
        int unsigned tries;
        bit          found;
        logic [31:0] addr;
        w = mk_word($urandom, $urandom, $urandom, $urandom, pick_reg(), pick_reg(),
                    pick_reg(), $urandom, $urandom);
        // noise words, kept away from loads of never-written memory
        if ($urandom_range(0, 99) < 8) begin
            if (w.opcode == OPC_LOAD && (w.funct3 == F3_WORD || w.funct3 == F3_BYTE_U))
                w.funct3[0] = 1'b1;
            return w;
        end
        pick = $urandom_range(0, 99);
        if (pick < 14)      kind = K_LW;
        else if (pick < 26) kind = K_LBU;
        else if (pick < 40) kind = K_SW;
        else if (pick < 52) kind = K_SB;
        else if (pick < 64) kind = K_ADDI;
        else if (pick < 76) kind = K_ADD;
        else if (pick < 84) kind = K_LUI;
        else if (pick < 91) kind = K_JALR;
        else if (pick < 94) kind = K_EBREAK;
        else                kind = K_BAD;
        // stores hit a small window most of the time
        widx = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 31)
                                           : $urandom_range(0, MEM_DEPTH - 1);
        lane = $urandom_range(0, 3);
        // loads only from words already holding data
        if (kind == K_LW || kind == K_LBU) begin
            found = 1'b0;
            for (tries = 0; tries < 8 && !found && touched_words.size() > 0; tries++) begin
                widx  = touched_words[$urandom_range(0, touched_words.size() - 1)];
                found = (kind == K_LBU) || (byte_written[widx] == 4'hf);
            end
            if (!found)
                kind = K_SW;
            else
                while (kind == K_LBU && !byte_written[widx][lane])
                    lane = (lane + 1) % 4;
        end
        addr = $urandom;
        addr = (addr & ~(ADDR_SPAN - 32'd1)) | (widx << 2) | lane;
        case (kind)
            K_LW: begin
                w.opcode    = OPC_LOAD;
                w.funct3    = F3_WORD;
                w.immediate = addr - reg_value(w.src1_reg);
            end
            K_LBU: begin
                w.opcode    = OPC_LOAD;
                w.funct3    = F3_BYTE_U;
                w.immediate = addr - reg_value(w.src1_reg);
            end
            K_SW: begin
                w.opcode    = OPC_STORE;
                w.funct3    = F3_WORD;
                w.immediate = addr - reg_value(w.src1_reg);
            end
            K_SB: begin
                w.opcode    = OPC_STORE;
                w.funct3    = F3_BYTE;
                w.immediate = addr - reg_value(w.src1_reg);
            end
            K_ADDI: begin
                w.opcode = OPC_IMM;
                w.funct3 = F3_ADD;
            end
            K_ADD: begin
                w.opcode = OPC_REG;
                w.funct3 = F3_ADD;
                w.funct7 = F7_BASE;
            end
            K_LUI: begin
                w.opcode = OPC_LUI;
                if ($urandom_range(0, 3) != 0)
                    w.immediate[11:0] = 12'd0;
            end
            K_JALR: begin
                w.opcode = OPC_JALR;
                w.funct3 = F3_JALR;
            end
            K_EBREAK: begin
                w.opcode  = OPC_SYSTEM;
                w.funct3  = F3_PRIV;
                w.funct12 = F12_EBREAK;
            end
            default: begin
                // near-miss encodings of each instruction class
                bad_base = kind_t'($urandom_range(K_LW, K_EBREAK));
                case (bad_base)
                    K_LW, K_LBU: begin
                        w.opcode = OPC_LOAD;
                        do w.funct3 = $urandom;
                        while (w.funct3 == F3_WORD || w.funct3 == F3_BYTE_U);
                    end
                    K_SW, K_SB: begin
                        w.opcode = OPC_STORE;
                        do w.funct3 = $urandom;
                        while (w.funct3 == F3_WORD || w.funct3 == F3_BYTE);
                    end
                    K_ADDI: begin
                        w.opcode = OPC_IMM;
                        do w.funct3 = $urandom;
                        while (w.funct3 == F3_ADD);
                    end
                    K_ADD: begin
                        w.opcode = OPC_REG;
                        do begin
                            w.funct3 = $urandom;
                            w.funct7 = $urandom;
                        end while (w.funct3 == F3_ADD && w.funct7 == F7_BASE);
                    end
                    K_JALR: begin
                        w.opcode = OPC_JALR;
                        do w.funct3 = $urandom;
                        while (w.funct3 == F3_JALR);
                    end
                    K_EBREAK: begin
                        w.opcode = OPC_SYSTEM;
                        do begin
                            w.funct3  = $urandom;
                            w.funct12 = $urandom;
                        end while (w.funct3 == F3_PRIV && w.funct12 == F12_EBREAK);
                    end
                    default: begin
                        do w.opcode = $urandom;
                        while (w.opcode inside {OPC_LOAD, OPC_STORE, OPC_IMM, OPC_REG,
                                                OPC_LUI, OPC_JALR, OPC_SYSTEM});
                    end
                endcase
            end
        endcase
        return w;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // sender: directed table, then random words
    initial begin : drive_words
        in_t  cur_word;
        bit   cur_fixed;
        out_t cur_fixed_res;
        out_t predicted;
        bit   took;
        bit   pausing;
        bit   pause_done;
        int   gen_idx;
        int   accepted_cnt;
        int   total;
        int   pause_at;
        int   idle_left;
        int   drain_cycles;

        s_valid <= 1'b0;
        s_data  <= '0;
        for (int i = 0; i < 32; i++)
            arch_regs[i] = 32'd0;
        for (int i = 0; i < MEM_DEPTH; i++) begin
            data_words[i]   = 32'd0;
            byte_written[i] = 4'd0;
        end

        // after reset, extremes, memory lanes, aliasing and error codes
        add_row(mk_word(OPC_REG, F3_ADD, F7_BASE, 12'd0, 5'd1, 5'd0, 5'd0, 32'd0, 32'h1000),
                CHECK_FIXED, mk_res(ST_OK, 1'b1, 32'd0, 1'b0, 32'd0, 1'b0));
        add_row(mk_word(OPC_IMM, F3_ADD, 7'd0, 12'd0, 5'd1, 5'd0, 5'd0, 32'h7fffffff,
                        32'h1004),
                CHECK_FIXED, mk_res(ST_OK, 1'b1, 32'h7fffffff, 1'b0, 32'd0, 1'b0));
        add_row(mk_word(OPC_IMM, F3_ADD, 7'd0, 12'd0, 5'd2, 5'd0, 5'd0, 32'h80000000,
                        32'h1008),
                CHECK_FIXED, mk_res(ST_OK, 1'b1, 32'h80000000, 1'b0, 32'd0, 1'b0));
        add_row(mk_word(OPC_REG, F3_ADD, F7_BASE, 12'd0, 5'd3, 5'd1, 5'd2, 32'd0, 32'h100c),
                CHECK_FIXED, mk_res(ST_OK, 1'b1, 32'hffffffff, 1'b0, 32'd0, 1'b0));
        add_row(mk_word(OPC_LUI, 3'd7, 7'd0, 12'd0, 5'd4, 5'd0, 5'd0, 32'hfffff000, 32'h1010),
                CHECK_FIXED, mk_res(ST_OK, 1'b1, 32'hfffff000, 1'b0, 32'd0, 1'b0));
        add_row(mk_word(OPC_LUI, 3'd0, 7'd0, 12'd0, 5'd0, 5'd0, 5'd0, 32'h12345000, 32'h1014),
                CHECK_FIXED, mk_res(ST_OK, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
        add_row(mk_word(OPC_STORE, F3_WORD, 7'd0, 12'd0, 5'd0, 5'd0, 5'd3, 32'h100, 32'h1018),
                CHECK_FIXED, mk_res(ST_OK, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
        add_row(mk_word(OPC_STORE, F3_WORD, 7'd0, 12'd0, 5'd0, 5'd0, 5'd1, 32'h104, 32'h101c),
                CHECK_FIXED, mk_res(ST_OK, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
        add_row(mk_word(OPC_STORE, F3_BYTE, 7'd0, 12'd0, 5'd0, 5'd0, 5'd2, 32'h107, 32'h1020),
                CHECK_FIXED, mk_res(ST_OK, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
        add_row(mk_word(OPC_LOAD, F3_WORD, 7'd0, 12'd0, 5'd5, 5'd0, 5'd0, 32'h100, 32'h1024),
                CHECK_FIXED, mk_res(ST_OK, 1'b1, 32'hffffffff, 1'b0, 32'd0, 1'b0));
        add_row(mk_word(OPC_LOAD, F3_BYTE_U, 7'd0, 12'd0, 5'd6, 5'd0, 5'd0, 32'h107,
                        32'h1028),
                CHECK_MODEL, '0);
        add_row(mk_word(OPC_LOAD, F3_BYTE_U, 7'd0, 12'd0, 5'd7, 5'd0, 5'd0, 32'h101,
                        32'h102c),
                CHECK_FIXED, mk_res(ST_OK, 1'b1, 32'h000000ff, 1'b0, 32'd0, 1'b0));
        // high address bits fold onto the same word
        add_row(mk_word(OPC_LOAD, F3_WORD, 7'd0, 12'd0, 5'd9, 5'd2, 5'd0, 32'h100, 32'h1030),
                CHECK_MODEL, '0);
        // load result used straight away
        add_row(mk_word(OPC_REG, F3_ADD, F7_BASE, 12'd0, 5'd10, 5'd5, 5'd9, 32'd0, 32'h1034),
                CHECK_MODEL, '0);
        add_row(mk_word(OPC_JALR, F3_JALR, 7'd0, 12'd0, 5'd8, 5'd1, 5'd0, 32'd1,
                        32'hfffffffc),
                CHECK_MODEL, '0);
        // jalr reading and writing the same register
        add_row(mk_word(OPC_JALR, F3_JALR, 7'd0, 12'd0, 5'd8, 5'd8, 5'd0, 32'hffffffff,
                        32'h0),
                CHECK_MODEL, '0);
        add_row(mk_word(OPC_JALR, F3_HALF, 7'd0, 12'd0, 5'd11, 5'd1, 5'd0, 32'd0, 32'h1040),
                CHECK_FIXED, mk_res(ST_BAD, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
        add_row(mk_word(OPC_SYSTEM, F3_PRIV, 7'd0, F12_EBREAK, 5'd0, 5'd0, 5'd0, 32'd1,
                        32'h1044),
                CHECK_FIXED, mk_res(ST_OK, 1'b0, 32'd0, 1'b0, 32'd0, 1'b1));
        // execution carries on after a halt
        add_row(mk_word(OPC_IMM, F3_ADD, 7'd0, 12'd0, 5'd12, 5'd12, 5'd0, 32'hffffffff,
                        32'h1048),
                CHECK_MODEL, '0);
        add_row(mk_word(OPC_SYSTEM, F3_PRIV, 7'd0, F12_ECALL, 5'd0, 5'd0, 5'd0, 32'd0,
                        32'h104c),
                CHECK_FIXED, mk_res(ST_BAD, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
        add_row(mk_word(OPC_SYSTEM, F3_HALF, 7'd0, F12_EBREAK, 5'd0, 5'd0, 5'd0, 32'd1,
                        32'h1050),
                CHECK_FIXED, mk_res(ST_BAD, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
        add_row(mk_word(OPC_REG, F3_ADD, F7_ALT, 12'd0, 5'd13, 5'd1, 5'd2, 32'd0, 32'h1054),
                CHECK_FIXED, mk_res(ST_BAD, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
        add_row(mk_word(OPC_IMM, F3_HALF, 7'd0, 12'd0, 5'd13, 5'd1, 5'd0, 32'd3, 32'h1058),
                CHECK_FIXED, mk_res(ST_BAD, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
        add_row(mk_word(OPC_LOAD, F3_BYTE, 7'd0, 12'd0, 5'd13, 5'd0, 5'd0, 32'h100, 32'h105c),
                CHECK_FIXED, mk_res(ST_BAD, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
        add_row(mk_word(OPC_STORE, F3_HALF, 7'd0, 12'd0, 5'd0, 5'd0, 5'd3, 32'h100, 32'h1060),
                CHECK_FIXED, mk_res(ST_BAD, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
        add_row(mk_word(OPC_UNUSED, 3'd7, 7'h7f, 12'hfff, 5'd31, 5'd31, 5'd31, 32'hffffffff,
                        32'hffffffff),
                CHECK_FIXED, mk_res(ST_BAD, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
        add_row(mk_word(OPC_ZERO, 3'd0, 7'd0, 12'd0, 5'd14, 5'd0, 5'd0, 32'd0, 32'd0),
                CHECK_FIXED, mk_res(ST_BAD, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
        add_row(mk_word(OPC_REG, F3_ADD, F7_BASE, 12'd0, 5'd31, 5'd31, 5'd5, 32'd0, 32'h1068),
                CHECK_MODEL, '0);

        total        = directed_rows.size() + RANDOM_ITEMS;
        pause_at     = directed_rows.size() + 400;
        gen_idx      = 0;
        accepted_cnt = 0;
        idle_left    = 0;
        pausing      = 1'b0;
        pause_done   = 1'b0;

        do @(posedge aclk); while (!aresetn);

        while (accepted_cnt < total) begin
            @(posedge aclk);
            took = s_valid && s_ready;
            if (took) begin
                predicted = exec_predict(cur_word);
                expected_results.push_back(cur_fixed ? cur_fixed_res : predicted);
                accepted_cnt++;
            end
            if (!s_valid || took) begin
                tail_phase = (gen_idx >= total - TAIL_ITEMS);
                // once in the run, let the pipe run dry before going on
                if (gen_idx == pause_at && !pause_done) begin
                    pause_done = 1'b1;
                    pausing    = 1'b1;
                end
                if (pausing && expected_results.size() == 0)
                    pausing = 1'b0;
                if (gen_idx >= total || pausing) begin
                    s_valid <= 1'b0;
                end else if (idle_left > 0) begin
                    idle_left--;
                    s_valid <= 1'b0;
                end else if (!tail_phase && !long_hold_active &&
                             $urandom_range(0, 9) == 0) begin
                    idle_left = $urandom_range(1, 17) - 1;
                    s_valid <= 1'b0;
                end else begin
                    if (gen_idx < directed_rows.size()) begin
                        cur_word      = directed_rows[gen_idx].word;
                        cur_fixed     = directed_rows[gen_idx].fixed;
                        cur_fixed_res = directed_rows[gen_idx].fixed_res;
                    end else begin
                        cur_word  = make_random_word();
                        cur_fixed = 1'b0;
                    end
                    gen_idx++;
                    s_valid <= 1'b1;
                    s_data  <= cur_word;
                end
            end
        end

        // drain, then a few more cycles for anything unexpected
        drain_cycles = 0;
        while (expected_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (PIPE_LATENCY * 4) @(posedge aclk);
        if (expected_results.size() != 0)
            $display("%0t: %0d results never arrived", $time, expected_results.size());
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // receiver: checks each result word and paces m_ready
    initial begin : check_results
        out_t want;
        int   stall_left;
        int   hold_left;
        bit   hold_done;

        m_ready    <= 1'b0;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        do @(posedge aclk); while (!aresetn);

        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                results_checked++;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, expected none, actual %p",
                             $time, m_data);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, m_data.status);
                    check_field("reg_written", want.reg_written, m_data.reg_written);
                    check_field("write_value", want.write_value, m_data.write_value);
                    check_field("jump_taken", want.jump_taken, m_data.jump_taken);
                    check_field("jump_target", want.jump_target, m_data.jump_target);
                    check_field("halted", want.halted, m_data.halted);
                end
            end
            // one long hold-off so that the pipe fills and stalls its input
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && results_checked >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
            long_hold_active = (hold_left > 0);
        end
    end

endmodule
